// File: rtl/core/svfs_pkg.sv
// ----------------------------------------------------------------------------
// svfs_pkg
// Shared types and codes of the script frame stack: item layouts, tags,
// status codes, opcodes, special slots and the sequencer states.
// ----------------------------------------------------------------------------
package svfs_pkg;

   localparam int SVFS_STACK_DEPTH = 1024;
   localparam int TOP_AFTER_W      = 11;

   // opcodes
   localparam logic [2:0] OP_PUSH  = 3'd0;
   localparam logic [2:0] OP_POP   = 3'd1;
   localparam logic [2:0] OP_PEEK  = 3'd2;
   localparam logic [2:0] OP_SETUP = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_WRITE = 3'd5;

   // entry tags
   localparam logic [1:0] TAG_INT   = 2'd0;
   localparam logic [1:0] TAG_FLOAT = 2'd1;
   localparam logic [1:0] TAG_UINT  = 2'd2;
   localparam logic [1:0] TAG_NONE  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_TYPE  = 2'd1;
   localparam logic [1:0] STAT_OVER  = 2'd2;
   localparam logic [1:0] STAT_UNDER = 2'd3;

   // difficulty levels
   localparam logic [1:0] LEVEL_EASY    = 2'd0;
   localparam logic [1:0] LEVEL_NORMAL  = 2'd1;
   localparam logic [1:0] LEVEL_HARD    = 2'd2;
   localparam logic [1:0] LEVEL_LUNATIC = 2'd3;

   // special read slots
   localparam logic signed [31:0] SLOT_RANDOM  = -32'sd10000;
   localparam logic signed [31:0] SLOT_TIME    = -32'sd9988;
   localparam logic signed [31:0] SLOT_DIFF    = -32'sd9959;
   localparam logic signed [31:0] SLOT_EASY    = -32'sd9953;
   localparam logic signed [31:0] SLOT_NORMAL  = -32'sd9952;
   localparam logic signed [31:0] SLOT_HARD    = -32'sd9951;
   localparam logic signed [31:0] SLOT_LUNATIC = -32'sd9550;
   localparam logic signed [31:0] SLOT_POP     = -32'sd1;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [1:0]         value_type;
      logic [31:0]        value_bits;
      logic signed [31:0] slot;
      logic [9:0]         frame_vars;
      logic [30:0]        time_now;
      logic [30:0]        random_word;
   } svfs_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [1:0]             result_type;
      logic [31:0]            result_bits;
      logic [TOP_AFTER_W-1:0] top_after;
   } svfs_rsp_type;

   typedef enum logic [2:0] {
      KIND_FIXED,
      KIND_PUSH,
      KIND_POP,
      KIND_PEEK,
      KIND_READ,
      KIND_WRITE,
      KIND_SETUP
   } svfs_kind_type;

   // what the execute cycle does with one item
   typedef struct packed {
      svfs_kind_type kind;
      logic [1:0]    status;
      logic [1:0]    rtype;
      logic [31:0]   bits;
   } svfs_plan_type;

   typedef struct packed {
      logic tag_we;
      logic word_we;
   } svfs_wr_type;

   typedef enum logic [1:0] {
      SM_CLEAR,
      SM_IDLE,
      SM_EXEC,
      SM_WALK
   } svfs_state_type;

endpackage

// File: rtl/core/script_vm_frame_stack_unit.sv
// ----------------------------------------------------------------------------
// script_vm_frame_stack_unit
// Typed value stack of a script machine with a frame base: push, pop, peek,
// frame setup and frame-relative variable access over tag and word memories.
// ----------------------------------------------------------------------------
//   port group   direction  handshake              payload
//   req_*        in         req_valid / req_stall  svfs_req_type
//   rsp_*        out        rsp_valid / rsp_stall  svfs_rsp_type
//   csr_*        in         csr_write_enable       difficulty (2 bits)
//
// In the accept cycle an item issues the memory read; in the next cycle the
// SM_EXEC state uses the registered read data and writes back. Frame setup
// then tags its frame_vars locals through the tag memory port in SM_WALK.
// After reset a clearing pass over every entry holds req_stall high.
// A stalled result holds the output register; the next item is taken once
// that register is free or being taken.
// ----------------------------------------------------------------------------
module script_vm_frame_stack_unit
   import svfs_pkg::*;
#(
   parameter int STACK_DEPTH = SVFS_STACK_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  svfs_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output svfs_rsp_type rsp_payload,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_write_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int TW = $clog2(STACK_DEPTH + 1);

   svfs_state_type state_ff, state_in;
   logic [TW-1:0]  top_ff, top_in;
   logic [TW-1:0]  base_ff, base_in;
   logic [1:0]     difficulty_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   svfs_rsp_type   rsp_ff, rsp_in;
   logic [AW-1:0]  walk_addr_ff, walk_addr_in;
   logic [9:0]     walk_left_ff, walk_left_in;

   svfs_plan_type  plan_ff, plan_dec;
   logic [AW-1:0]  addr_ff, addr_dec;
   svfs_req_type   req_ff;
   logic           rd_en_dec;

   svfs_wr_type    wr_ctl;
   logic [AW-1:0]  wr_addr;
   logic [1:0]     wr_tag;
   logic [31:0]    wr_word;
   logic [1:0]     rd_tag;
   logic [31:0]    rd_word;

   logic           accept;
   logic           rsp_take;
   logic [31:0]    top_wide;

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = !(state_ff == SM_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   svfs_decode #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW),
      .TW          (TW)
   ) u_decode (
      .req_i        (req_payload),
      .top_i        (top_ff),
      .base_i       (base_ff),
      .difficulty_i (difficulty_ff),
      .plan_o       (plan_dec),
      .rd_en_o      (rd_en_dec),
      .addr_o       (addr_dec)
   );

   svfs_store #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_ctl  (wr_ctl),
      .wr_addr (wr_addr),
      .wr_tag  (wr_tag),
      .wr_word (wr_word),
      .rd_en   (accept && rd_en_dec),
      .rd_addr (addr_dec),
      .rd_tag  (rd_tag),
      .rd_word (rd_word)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SM_CLEAR: begin
            if (walk_addr_ff == AW'(STACK_DEPTH - 1)) begin
               state_in = SM_IDLE;
            end
         end
         SM_IDLE: begin
            if (accept) begin
               state_in = SM_EXEC;
            end
         end
         SM_EXEC: begin
            if (plan_ff.kind == KIND_SETUP && req_ff.frame_vars != '0) begin
               state_in = SM_WALK;
            end else begin
               state_in = SM_IDLE;
            end
         end
         SM_WALK: begin
            if (walk_left_ff == 10'd1) begin
               state_in = SM_IDLE;
            end
         end
         default: begin
            state_in = SM_CLEAR;
         end
      endcase
   end

   // datapath and memory writes
   always_comb begin
      top_in       = top_ff;
      base_in      = base_ff;
      walk_addr_in = walk_addr_ff;
      walk_left_in = walk_left_ff;
      wr_ctl       = '0;
      wr_addr      = addr_ff;
      wr_tag       = req_ff.value_type;
      wr_word      = req_ff.value_bits;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      top_wide     = '0;
      unique case (state_ff)
         SM_CLEAR: begin
            wr_ctl       = '{tag_we: 1'b1, word_we: 1'b1};
            wr_addr      = walk_addr_ff;
            wr_tag       = TAG_NONE;
            wr_word      = '0;
            walk_addr_in = walk_addr_ff + AW'(1);
         end
         SM_IDLE: begin
            walk_addr_in = walk_addr_ff;
         end
         SM_EXEC: begin
            rsp_in.status      = STAT_OK;
            rsp_in.result_type = TAG_NONE;
            rsp_in.result_bits = '0;
            unique case (plan_ff.kind)
               KIND_FIXED: begin
                  rsp_in.status      = plan_ff.status;
                  rsp_in.result_type = plan_ff.rtype;
                  rsp_in.result_bits = plan_ff.bits;
               end
               KIND_PUSH: begin
                  wr_ctl = '{tag_we: 1'b1, word_we: 1'b1};
                  top_in = top_ff + TW'(1);
               end
               KIND_POP, KIND_PEEK: begin
                  rsp_in.result_type = rd_tag;
                  rsp_in.result_bits = rd_word;
                  if (plan_ff.kind == KIND_POP) begin
                     top_in = top_ff - TW'(1);
                  end
               end
               KIND_READ: begin
                  rsp_in.result_type = rd_tag;
                  if (rd_tag == TAG_INT || rd_tag == TAG_FLOAT) begin
                     rsp_in.result_bits = rd_word;
                  end else begin
                     rsp_in.status = STAT_TYPE;
                  end
               end
               KIND_WRITE: begin
                  wr_ctl = '{tag_we: 1'b1, word_we: 1'b1};
               end
               KIND_SETUP: begin
                  // save the old base, then tag the locals in the walk
                  wr_ctl       = '{tag_we: 1'b1, word_we: 1'b1};
                  wr_tag       = TAG_UINT;
                  wr_word      = 32'(base_ff);
                  base_in      = top_ff + TW'(1);
                  top_in       = TW'(32'(top_ff) + 32'(req_ff.frame_vars) + 32'd1);
                  walk_addr_in = AW'(32'(top_ff) + 32'd1);
                  walk_left_in = req_ff.frame_vars;
               end
               default: begin
                  rsp_in.status = STAT_OK;
               end
            endcase
            top_wide         = 32'(top_in);
            rsp_in.top_after = top_wide[TOP_AFTER_W-1:0];
            rsp_valid_in     = 1'b1;
         end
         SM_WALK: begin
            wr_ctl       = '{tag_we: 1'b1, word_we: 1'b0};
            wr_addr      = walk_addr_ff;
            wr_tag       = TAG_INT;
            walk_addr_in = walk_addr_ff + AW'(1);
            walk_left_in = walk_left_ff - 10'd1;
         end
         default: begin
            wr_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SM_CLEAR;
         top_ff        <= '0;
         base_ff       <= '0;
         difficulty_ff <= LEVEL_EASY;
         rsp_valid_ff  <= 1'b0;
         walk_addr_ff  <= '0;
         walk_left_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_addr_ff <= walk_addr_in;
         walk_left_ff <= walk_left_in;
         if (csr_write_enable) begin
            difficulty_ff <= csr_write_data;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         plan_ff <= plan_dec;
         addr_ff <= addr_dec;
         req_ff  <= req_payload;
      end
   end

endmodule

// File: rtl/core/svfs_store.sv
// ----------------------------------------------------------------------------
// svfs_store
// Tag and word memories of the stack: one write port, one read port each,
// read data registered.
// ----------------------------------------------------------------------------
module svfs_store
   import svfs_pkg::*;
#(
   parameter int STACK_DEPTH = SVFS_STACK_DEPTH,
   parameter int AW          = $clog2(STACK_DEPTH)
) (
   input  logic          clock,
   input  svfs_wr_type   wr_ctl,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_tag,
   input  logic [31:0]   wr_word,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [1:0]    rd_tag,
   output logic [31:0]   rd_word
);

   logic [1:0]  tag_mem  [STACK_DEPTH];
   logic [31:0] word_mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_ctl.tag_we) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (rd_en) begin
         rd_tag <= tag_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.word_we) begin
         word_mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_word <= word_mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/svfs_decode.sv
// ----------------------------------------------------------------------------
// svfs_decode
// Classifies an incoming item against top and base: error checks, special
// slots, and the memory address that the item reads or writes.
// ----------------------------------------------------------------------------
module svfs_decode
   import svfs_pkg::*;
#(
   parameter int STACK_DEPTH = SVFS_STACK_DEPTH,
   parameter int AW          = $clog2(STACK_DEPTH),
   parameter int TW          = $clog2(STACK_DEPTH + 1)
) (
   input  svfs_req_type  req_i,
   input  logic [TW-1:0] top_i,
   input  logic [TW-1:0] base_i,
   input  logic [1:0]    difficulty_i,
   output svfs_plan_type plan_o,
   output logic          rd_en_o,
   output logic [AW-1:0] addr_o
);

   logic [31:0]   idx_sum;
   logic          idx_oob;
   logic          top_zero;
   logic          top_full;
   logic [31:0]   setup_need;
   logic [TW-1:0] top_dec;

   assign idx_sum    = 32'(base_i) + {3'b000, req_i.slot[30:2]};
   assign idx_oob    = idx_sum >= 32'(STACK_DEPTH);
   assign top_zero   = top_i == '0;
   assign top_full   = 32'(top_i) >= 32'(STACK_DEPTH);
   assign setup_need = 32'(top_i) + 32'(req_i.frame_vars) + 32'd1;
   assign top_dec    = top_i - TW'(1);

   always_comb begin
      plan_o.kind   = KIND_FIXED;
      plan_o.status = STAT_OK;
      plan_o.rtype  = TAG_NONE;
      plan_o.bits   = '0;
      rd_en_o       = 1'b0;
      addr_o        = '0;
      unique case (req_i.opcode)
         OP_PUSH: begin
            if (req_i.value_type == TAG_NONE) begin
               plan_o.status = STAT_TYPE;
            end else if (top_full) begin
               plan_o.status = STAT_OVER;
            end else begin
               plan_o.kind = KIND_PUSH;
               addr_o      = top_i[AW-1:0];
            end
         end
         OP_POP, OP_PEEK: begin
            if (top_zero) begin
               plan_o.status = STAT_UNDER;
            end else begin
               plan_o.kind = (req_i.opcode == OP_POP) ? KIND_POP : KIND_PEEK;
               rd_en_o     = 1'b1;
               addr_o      = top_dec[AW-1:0];
            end
         end
         OP_SETUP: begin
            if (setup_need > 32'(STACK_DEPTH)) begin
               plan_o.status = STAT_OVER;
            end else begin
               plan_o.kind = KIND_SETUP;
               addr_o      = top_i[AW-1:0];
            end
         end
         OP_READ: begin
            if (!req_i.slot[31]) begin
               if (idx_oob) begin
                  plan_o.status = STAT_UNDER;
               end else begin
                  plan_o.kind = KIND_READ;
                  rd_en_o     = 1'b1;
                  addr_o      = idx_sum[AW-1:0];
               end
            end else begin
               unique case (req_i.slot)
                  SLOT_RANDOM: begin
                     plan_o.rtype = TAG_INT;
                     plan_o.bits  = {1'b0, req_i.random_word};
                  end
                  SLOT_TIME: begin
                     plan_o.rtype = TAG_INT;
                     plan_o.bits  = {1'b0, req_i.time_now};
                  end
                  SLOT_DIFF: begin
                     plan_o.rtype = TAG_INT;
                     plan_o.bits  = {30'd0, difficulty_i};
                  end
                  SLOT_EASY: begin
                     plan_o.rtype = TAG_INT;
                     plan_o.bits  = {31'd0, difficulty_i == LEVEL_EASY};
                  end
                  SLOT_NORMAL: begin
                     plan_o.rtype = TAG_INT;
                     plan_o.bits  = {31'd0, difficulty_i == LEVEL_NORMAL};
                  end
                  SLOT_HARD: begin
                     plan_o.rtype = TAG_INT;
                     plan_o.bits  = {31'd0, difficulty_i == LEVEL_HARD};
                  end
                  SLOT_LUNATIC: begin
                     plan_o.rtype = TAG_INT;
                     plan_o.bits  = {31'd0, difficulty_i == LEVEL_LUNATIC};
                  end
                  SLOT_POP: begin
                     if (top_zero) begin
                        plan_o.status = STAT_UNDER;
                     end else begin
                        plan_o.kind = KIND_POP;
                        rd_en_o     = 1'b1;
                        addr_o      = top_dec[AW-1:0];
                     end
                  end
                  default: begin
                     plan_o.rtype = TAG_NONE;
                  end
               endcase
            end
         end
         OP_WRITE: begin
            // negative slot: drop the write
            if (!req_i.slot[31]) begin
               if (idx_oob) begin
                  plan_o.status = STAT_UNDER;
               end else if (req_i.value_type != TAG_INT &&
                            req_i.value_type != TAG_FLOAT) begin
                  plan_o.status = STAT_TYPE;
               end else begin
                  plan_o.kind = KIND_WRITE;
                  addr_o      = idx_sum[AW-1:0];
               end
            end
         end
         default: begin
            plan_o.status = STAT_OK;
         end
      endcase
   end

endmodule

// File: verif/script_vm_frame_stack_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_vm_frame_stack_unit_tb
// Self-checking bench for the script frame stack. A scoreboard class keeps
// its own copy of the tag and word memories, the top index, the frame base
// and the difficulty level. It predicts one result per accepted item, and
// every result taken from the block is checked against the oldest prediction.
// A short directed sequence covers the edge cases: empty and full stack, bad
// tags, out-of-range slots and every special slot. Six random phases follow,
// each at a difficulty level written before it, with random gaps on both
// sides, stretches without gaps and one long result hold-off.
// ----------------------------------------------------------------------------
module script_vm_frame_stack_unit_tb
   import svfs_pkg::*;
();

   localparam int DEPTH       = SVFS_STACK_DEPTH;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 240;
   localparam int LONG_HOLD   = 300;

   // opcodes the block leaves unused
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   class stack_scoreboard;
      logic [1:0]   tags  [DEPTH];
      logic [31:0]  words [DEPTH];
      int unsigned  top;
      int unsigned  base;
      logic [1:0]   level;
      svfs_rsp_type owed [$];
      int           errors;

      function new();
         foreach (tags[i]) begin
            tags[i]  = TAG_NONE;
            words[i] = '0;
         end
         top    = 0;
         base   = 0;
         level  = LEVEL_EASY;
         errors = 0;
      endfunction

      // pop or peek the top entry; empty stack flags underflow
      function svfs_rsp_type take_top(bit remove);
         svfs_rsp_type o;
         o             = '0;
         o.status      = STAT_UNDER;
         o.result_type = TAG_NONE;
         if (top != 0) begin
            o.status      = STAT_OK;
            o.result_type = tags[top - 1];
            o.result_bits = words[top - 1];
            if (remove) top--;
         end
         return o;
      endfunction

      function svfs_rsp_type apply_op(svfs_req_type r);
         svfs_rsp_type o;
         logic [63:0]  idx;
         o             = '0;
         o.status      = STAT_OK;
         o.result_type = TAG_NONE;
         idx           = 64'(base) + 64'(r.slot[31:2]);
         case (r.opcode)
            OP_PUSH: begin
               if (r.value_type == TAG_NONE) o.status = STAT_TYPE;
               else if (top >= DEPTH) o.status = STAT_OVER;
               else begin
                  tags[top]  = r.value_type;
                  words[top] = r.value_bits;
                  top++;
               end
            end
            OP_POP:  o = take_top(1'b1);
            OP_PEEK: o = take_top(1'b0);
            OP_SETUP: begin
               if (top + 1 + r.frame_vars > DEPTH) o.status = STAT_OVER;
               else begin
                  // save the old base, then tag the locals; their words stay
                  tags[top]  = TAG_UINT;
                  words[top] = 32'(base);
                  top++;
                  base = top;
                  for (int i = 0; i < r.frame_vars; i++) tags[base + i] = TAG_INT;
                  top += r.frame_vars;
               end
            end
            OP_READ: begin
               if (!r.slot[31]) begin
                  if (idx >= DEPTH) o.status = STAT_UNDER;
                  else if (tags[idx] == TAG_UINT || tags[idx] == TAG_NONE) begin
                     o.status      = STAT_TYPE;
                     o.result_type = tags[idx];
                  end else begin
                     o.result_type = tags[idx];
                     o.result_bits = words[idx];
                  end
               end else begin
                  o.result_type = TAG_INT;
                  case (r.slot)
                     SLOT_RANDOM:  o.result_bits = {1'b0, r.random_word};
                     SLOT_TIME:    o.result_bits = {1'b0, r.time_now};
                     SLOT_DIFF:    o.result_bits = 32'(level);
                     SLOT_EASY:    o.result_bits = 32'(level == LEVEL_EASY);
                     SLOT_NORMAL:  o.result_bits = 32'(level == LEVEL_NORMAL);
                     SLOT_HARD:    o.result_bits = 32'(level == LEVEL_HARD);
                     SLOT_LUNATIC: o.result_bits = 32'(level == LEVEL_LUNATIC);
                     SLOT_POP:     o = take_top(1'b1);
                     default:      o.result_type = TAG_NONE;
                  endcase
               end
            end
            OP_WRITE: begin
               if (!r.slot[31]) begin
                  if (idx >= DEPTH) o.status = STAT_UNDER;
                  else if (r.value_type != TAG_INT && r.value_type != TAG_FLOAT)
                     o.status = STAT_TYPE;
                  else begin
                     tags[idx]  = r.value_type;
                     words[idx] = r.value_bits;
                  end
               end
            end
            default: ;
         endcase
         o.top_after = TOP_AFTER_W'(top);
         return o;
      endfunction

      function void note(svfs_req_type r);
         owed.push_back(apply_op(r));
      endfunction

      function void flag(string what, svfs_rsp_type want, svfs_rsp_type got);
         errors++;
         if (errors <= 10)
            $display("mismatch (%s): expected st=%0d ty=%0d bits=%08h top=%0d",
                     what, want.status, want.result_type, want.result_bits,
                     want.top_after);
         if (errors <= 10)
            $display("                 got st=%0d ty=%0d bits=%08h top=%0d",
                     got.status, got.result_type, got.result_bits, got.top_after);
      endfunction

      function void check(svfs_rsp_type got);
         svfs_rsp_type want;
         if (owed.size() == 0) begin
            flag("no item expected", '0, got);
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status || got.result_type !== want.result_type ||
             got.result_bits !== want.result_bits || got.top_after !== want.top_after)
            flag("field differs", want, got);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   svfs_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   svfs_rsp_type rsp_payload;
   logic         csr_write_enable;
   logic [1:0]   csr_write_data;

   stack_scoreboard book;
   bit              quiet;
   bit              hold_off;

   script_vm_frame_stack_unit #(.STACK_DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic svfs_req_type compose(logic [2:0] op, logic [1:0] vt,
                                            logic [31:0] bits, logic signed [31:0] slot,
                                            logic [9:0] nvars);
      svfs_req_type r;
      r.opcode      = op;
      r.value_type  = vt;
      r.value_bits  = bits;
      r.slot        = slot;
      r.frame_vars  = nvars;
      r.time_now    = 31'($urandom);
      r.random_word = 31'($urandom);
      return r;
   endfunction

   // mostly well-formed frame traffic, slots near the live frame
   function automatic svfs_req_type pick_item();
      int unsigned        roll;
      int unsigned        span;
      int unsigned        sel;
      logic [2:0]         op;
      logic [1:0]         vt;
      logic [31:0]        bits;
      logic signed [31:0] slot;
      logic [9:0]         nvars;
      roll  = $urandom_range(0, 99);
      bits  = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
      vt    = ($urandom_range(0, 19) == 0) ? TAG_NONE : 2'($urandom_range(0, 2));
      nvars = 10'($urandom);
      span  = (book.top > book.base ? book.top - book.base : 0) + 3;
      slot  = 32'(4 * $urandom_range(0, span) + $urandom_range(0, 3));
      // drain a nearly full stack
      if (book.top > 900 && roll < 60) roll = 30;
      if (roll < 22) op = OP_PUSH;
      else if (roll < 38) op = OP_POP;
      else if (roll < 44) op = OP_PEEK;
      else if (roll < 52) begin
         op  = OP_SETUP;
         sel = $urandom_range(0, 19);
         if (sel < 14) nvars = 10'($urandom_range(0, 6));
         else if (sel < 19) nvars = 10'($urandom_range(7, 40));
         else nvars = 10'($urandom_range(100, 1023));
      end else if (roll < 70) op = OP_READ;
      else if (roll < 80) begin
         op = OP_READ;
         case ($urandom_range(0, 9))
            0: slot = SLOT_RANDOM;
            1: slot = SLOT_TIME;
            2: slot = SLOT_DIFF;
            3: slot = SLOT_EASY;
            4: slot = SLOT_NORMAL;
            5: slot = SLOT_HARD;
            6: slot = SLOT_LUNATIC;
            7: slot = SLOT_POP;
            8: slot = {1'b1, 31'($urandom)};
            default: slot = 32'sd0 - 32'($urandom_range(2, 20000));
         endcase
      end else if (roll < 95) begin
         op = OP_WRITE;
         vt = ($urandom_range(0, 6) == 0) ? 2'($urandom_range(2, 3))
                                          : 2'($urandom_range(0, 1));
      end else if (roll < 97) begin
         op   = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
         slot = $urandom;
      end else op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      return compose(op, vt, bits, slot, nvars);
   endfunction

   task automatic send_item(input svfs_req_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      book.note(item);
   endtask

   // drop valid and hold until every predicted item has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.owed.size() != 0) @(posedge clock);
   endtask

   task automatic write_level(input logic [1:0] lvl);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= lvl;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      book.level = lvl;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check(rsp_payload);
   end

   initial begin : result_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if (hold_off) begin
            hold     = LONG_HOLD;
            hold_off = 1'b0;
         end else hold = quiet ? 0 : $urandom_range(0, 8);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : watchdog
      #(5_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      svfs_req_type item;
      logic [1:0]   lvl;
      book             = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = LEVEL_EASY;
      quiet            = 1'b0;
      hold_off         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_level(LEVEL_EASY);

      // empty stack, bad tag, then a few typed entries
      send_item(compose(OP_POP, TAG_INT, '0, 32'sd0, '0));
      send_item(compose(OP_READ, TAG_INT, '0, SLOT_POP, '0));
      send_item(compose(OP_PUSH, TAG_NONE, '1, 32'sd0, '0));
      send_item(compose(OP_PUSH, TAG_INT, '1, 32'sd0, '1));
      send_item(compose(OP_PUSH, TAG_FLOAT, 32'h3F80_0000, 32'sd0, '0));
      send_item(compose(OP_PUSH, TAG_UINT, '0, 32'sd0, '0));
      send_item(compose(OP_PEEK, TAG_INT, '0, 32'sd0, '0));
      send_item(compose(OP_READ, TAG_INT, '0, 32'sd8, '1));
      send_item(compose(OP_READ, TAG_INT, '0, 32'sh7FFF_FFFF, '0));
      send_item(compose(OP_WRITE, TAG_UINT, '1, 32'sd12, '0));
      send_item(compose(OP_WRITE, TAG_INT, '1, -32'sd7, '0));
      // entries above the top stay reachable
      send_item(compose(OP_WRITE, TAG_FLOAT, 32'hDEAD_BEEF, 32'sd13, '0));
      send_item(compose(OP_READ, TAG_INT, '0, 32'sd15, '0));
      send_item(compose(OP_READ, TAG_INT, '0, 32'sd40, '0));
      item             = compose(OP_READ, TAG_INT, '0, SLOT_RANDOM, '0);
      item.random_word = '1;
      send_item(item);
      item          = compose(OP_READ, TAG_INT, '0, SLOT_TIME, '0);
      item.time_now = '1;
      send_item(item);
      send_item(compose(OP_READ, TAG_INT, '0, SLOT_DIFF, '0));
      send_item(compose(OP_READ, TAG_INT, '0, SLOT_EASY, '0));
      send_item(compose(OP_READ, TAG_INT, '0, SLOT_NORMAL, '0));
      send_item(compose(OP_READ, TAG_INT, '0, SLOT_HARD, '0));
      send_item(compose(OP_READ, TAG_INT, '0, SLOT_LUNATIC, '0));
      send_item(compose(OP_READ, TAG_INT, '0, SLOT_POP, '0));
      // frame one entry too large, then one that fills the stack exactly
      send_item(compose(OP_SETUP, TAG_INT, '0, 32'sd0, 10'd1022));
      send_item(compose(OP_SETUP, TAG_INT, '0, 32'sd0, 10'd1021));
      send_item(compose(OP_PUSH, TAG_INT, '1, 32'sd0, '0));
      send_item(compose(OP_READ, TAG_INT, '0, 32'sd4083, '0));
      send_item(compose(OP_WRITE, TAG_INT, '1, 32'sd4084, '0));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0:       lvl = LEVEL_NORMAL;
            1:       lvl = LEVEL_LUNATIC;
            2:       lvl = LEVEL_HARD;
            3:       lvl = LEVEL_EASY;
            4:       lvl = LEVEL_LUNATIC;
            default: lvl = 2'($urandom);
         endcase
         write_level(lvl);
         quiet = (p == 1 || p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 40) hold_off = 1'b1;
            send_item(pick_item());
         end
      end
      quiet = 1'b0;
      drain();
      repeat (16) @(posedge clock);

      if (book.errors == 0 && book.owed.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/svfs_pkg.sv
rtl/core/svfs_store.sv
rtl/core/svfs_decode.sv
rtl/core/script_vm_frame_stack_unit.sv
verif/script_vm_frame_stack_unit_tb.sv
